// ===== hdl/greedy_voxel_box_merge_macros.svh =====
// Assertion macros for the greedy voxel box merger checker.
// Depends on nothing; included by the checker file.
`ifndef GREEDY_VOXEL_BOX_MERGE_MACROS_SVH
`define GREEDY_VOXEL_BOX_MERGE_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define GVBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define GVBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/gvbm_pkg.sv =====
// Package for the greedy voxel box merger: payload structs, codes, FSM enums.
// No dependencies; used by greedy_voxel_box_merge and its checker.
`default_nettype none

package gvbm_pkg;

  localparam int MAX_DIM_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RST = 5'd16;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [3:0]  row_x;
    logic [3:0]  row_y;
    logic [15:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic       box_valid;
    logic       done_res;
    logic [3:0] from_x;
    logic [3:0] from_y;
    logic [3:0] from_z;
    logic [3:0] to_x;
    logic [3:0] to_y;
    logic [3:0] to_z;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_TRY,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_CLR_RD,
    ST_CLR_EV,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_SEED,
    PH_X,
    PH_Y,
    PH_Z,
    PH_END
  } phase_t;

endpackage

`default_nettype wire

// ===== hdl/greedy_voxel_box_merge.sv =====
// Greedy 3D box merger: top level with the row memory and its sequencer.
// Depends on gvbm_pkg.
`default_nettype none

// Splits an occupancy grid into axis-aligned boxes.
//
// Load (op 0): if (row_x,row_y) is in range and sz is nonzero, writes a
// z-row there and restarts the scan, then hands over a result.
//
// Pop (op 1): scans rows from the saved position, then grows a box along x,
// then y, then z. All work goes through one row memory (one read and
// one write per cycle, registered read). Steps of a pop:
//   - the transfer;
//   - a read and a check per row scanned, plus a move per next x column;
//   - when nothing is found, a done report;
//   - a read and a write to clear the seed;
//   - per extension trial, a setup, reads of rows checked, rows cleared;
//   - closing the box;
//   - handing the result over.
//
// One item is in flight at a time. The result register lets a finished
// result wait while the next item enters.
//
// After reset the memory is swept to zero before the first item is taken.
// The sweep writes all 2**(2*clog2(MAX_DIM)) rows (256 at MAX_DIM 16).
module greedy_voxel_box_merge #(
  parameter int MAX_DIM = gvbm_pkg::MAX_DIM_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  gvbm_pkg::in_item_t           in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output gvbm_pkg::out_item_t                out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [gvbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [gvbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW  = $clog2(MAX_DIM);
  localparam int SW  = $clog2(MAX_DIM + 1);
  localparam int MAW = 2 * AW;
  localparam int MD  = 1 << MAW;
  localparam int CW  = SW + 4;

  // configuration
  logic [gvbm_pkg::CFG_DATA_W-1:0] cfg_x_r, cfg_y_r, cfg_z_r;
  logic [SW-1:0] sx, sy, sz;

  // sequencer
  gvbm_pkg::state_t state_r, state_nxt;
  gvbm_pkg::phase_t phase_r, phase_nxt;
  logic [SW-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic [AW-1:0]  zs_r, zs_nxt;
  logic [AW-1:0]  pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt, pos_z_r, pos_z_nxt;
  logic [AW-1:0]  bx_r, bx_nxt, by_r, by_nxt, bz_r, bz_nxt;
  logic [AW-1:0]  tx_r, tx_nxt, ty_r, ty_nxt, tz_r, tz_nxt;
  logic [AW-1:0]  rx0_r, rx0_nxt, rx1_r, rx1_nxt, ry0_r, ry0_nxt, ry1_r, ry1_nxt;
  logic [AW-1:0]  rb_r, rb_nxt;
  logic           res_box_r, res_box_nxt, res_done_r, res_done_nxt;
  logic [MAW-1:0] wipe_r, wipe_nxt;
  logic           out_valid_r, out_valid_nxt;
  gvbm_pkg::out_item_t out_data_r, out_data_nxt;

  // row memory
  logic [MAX_DIM-1:0] mem [MD];
  logic [MAX_DIM-1:0] rd_data_r;
  logic               mem_we;
  logic [MAW-1:0]     mem_wa, mem_ra;
  logic [MAX_DIM-1:0] mem_wd;

  // helpers
  logic [MAX_DIM-1:0] sz_mask, scan_mask;
  logic [AW-1:0]      low_z;
  logic               reg_last;
  logic [SW-1:0]      tx_inc, ty_inc, tz_inc;
  logic               load_ok;

  // saturate the size registers at MAX_DIM
  always_comb begin
    sx = (6'(cfg_x_r) > 6'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(cfg_x_r);
    sy = (6'(cfg_y_r) > 6'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(cfg_y_r);
    sz = (6'(cfg_z_r) > 6'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(cfg_z_r);
  end

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_x_r <= gvbm_pkg::CFG_SIZE_RST;
      cfg_y_r <= gvbm_pkg::CFG_SIZE_RST;
      cfg_z_r <= gvbm_pkg::CFG_SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gvbm_pkg::CFG_SIZE_X: cfg_x_r <= cfg_data;
        gvbm_pkg::CFG_SIZE_Y: cfg_y_r <= cfg_data;
        gvbm_pkg::CFG_SIZE_Z: cfg_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // row memory: one write, one registered read
  assign mem_ra = {cx_r[AW-1:0], cy_r[AW-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // scan and region helpers
  assign sz_mask   = ~({MAX_DIM{1'b1}} << sz);
  assign scan_mask = rd_data_r & ({MAX_DIM{1'b1}} << zs_r) & sz_mask;

  always_comb begin
    low_z = '0;
    for (int i = MAX_DIM - 1; i >= 0; i--) begin
      if (scan_mask[i]) begin
        low_z = AW'(i);
      end
    end
  end

  assign reg_last = (cx_r[AW-1:0] == rx1_r) && (cy_r[AW-1:0] == ry1_r);
  assign tx_inc   = SW'(tx_r) + SW'(1);
  assign ty_inc   = SW'(ty_r) + SW'(1);
  assign tz_inc   = SW'(tz_r) + SW'(1);
  assign load_ok  = (CW'(in_data.row_x) < CW'(sx)) && (CW'(in_data.row_y) < CW'(sy))
                    && (sz != '0);

  assign in_ready  = (state_r == gvbm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gvbm_pkg::ST_WIPE;
      phase_r     <= gvbm_pkg::PH_SEED;
      wipe_r      <= '0;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      wipe_r      <= wipe_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      pos_z_r     <= pos_z_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    zs_r       <= zs_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    bz_r       <= bz_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    tz_r       <= tz_nxt;
    rx0_r      <= rx0_nxt;
    rx1_r      <= rx1_nxt;
    ry0_r      <= ry0_nxt;
    ry1_r      <= ry1_nxt;
    rb_r       <= rb_nxt;
    res_box_r  <= res_box_nxt;
    res_done_r <= res_done_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    wipe_nxt      = wipe_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    zs_nxt        = zs_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    pos_z_nxt     = pos_z_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    bz_nxt        = bz_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    tz_nxt        = tz_r;
    rx0_nxt       = rx0_r;
    rx1_nxt       = rx1_r;
    ry0_nxt       = ry0_r;
    ry1_nxt       = ry1_r;
    rb_nxt        = rb_r;
    res_box_nxt   = res_box_r;
    res_done_nxt  = res_done_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = {cx_r[AW-1:0], cy_r[AW-1:0]};
    mem_wd        = rd_data_r & ~(MAX_DIM'(1) << rb_r);

    unique case (state_r)
      // zero sweep after reset
      gvbm_pkg::ST_WIPE: begin
        mem_we   = 1'b1;
        mem_wa   = wipe_r;
        mem_wd   = '0;
        wipe_nxt = wipe_r + MAW'(1);
        if (wipe_r == {MAW{1'b1}}) begin
          state_nxt = gvbm_pkg::ST_IDLE;
        end
      end

      gvbm_pkg::ST_IDLE: begin
        res_box_nxt  = 1'b0;
        res_done_nxt = 1'b0;
        if (in_valid) begin
          if (in_data.op == gvbm_pkg::OP_LOAD) begin
            if (load_ok) begin
              mem_we    = 1'b1;
              mem_wa    = {AW'(in_data.row_x), AW'(in_data.row_y)};
              mem_wd    = MAX_DIM'(in_data.row_bits) & sz_mask;
              pos_x_nxt = '0;
              pos_y_nxt = '0;
              pos_z_nxt = '0;
            end
            state_nxt = gvbm_pkg::ST_OUT;
          end else begin
            cx_nxt    = SW'(pos_x_r);
            cy_nxt    = SW'(pos_y_r);
            zs_nxt    = pos_z_r;
            state_nxt = gvbm_pkg::ST_SCAN_RD;
          end
        end
      end

      // walk rows in x-major order
      gvbm_pkg::ST_SCAN_RD: begin
        if (cx_r >= sx) begin
          res_done_nxt = 1'b1;
          state_nxt    = gvbm_pkg::ST_OUT;
        end else if (cy_r >= sy) begin
          cx_nxt = cx_r + SW'(1);
          cy_nxt = '0;
          zs_nxt = '0;
        end else begin
          state_nxt = gvbm_pkg::ST_SCAN_EV;
        end
      end

      gvbm_pkg::ST_SCAN_EV: begin
        if (scan_mask != '0) begin
          pos_x_nxt = cx_r[AW-1:0];
          pos_y_nxt = cy_r[AW-1:0];
          pos_z_nxt = low_z;
          bx_nxt    = cx_r[AW-1:0];
          by_nxt    = cy_r[AW-1:0];
          bz_nxt    = low_z;
          tx_nxt    = cx_r[AW-1:0];
          ty_nxt    = cy_r[AW-1:0];
          tz_nxt    = low_z;
          rx0_nxt   = cx_r[AW-1:0];
          rx1_nxt   = cx_r[AW-1:0];
          ry0_nxt   = cy_r[AW-1:0];
          ry1_nxt   = cy_r[AW-1:0];
          rb_nxt    = low_z;
          phase_nxt = gvbm_pkg::PH_SEED;
          state_nxt = gvbm_pkg::ST_CLR_RD;
        end else begin
          cy_nxt    = cy_r + SW'(1);
          zs_nxt    = '0;
          state_nxt = gvbm_pkg::ST_SCAN_RD;
        end
      end

      // set up the next extension region
      gvbm_pkg::ST_TRY: begin
        unique case (phase_r)
          gvbm_pkg::PH_X: begin
            if (tx_inc < sx) begin
              rx0_nxt   = tx_inc[AW-1:0];
              rx1_nxt   = tx_inc[AW-1:0];
              ry0_nxt   = by_r;
              ry1_nxt   = by_r;
              rb_nxt    = bz_r;
              cx_nxt    = tx_inc;
              cy_nxt    = SW'(by_r);
              state_nxt = gvbm_pkg::ST_CHK_RD;
            end else begin
              phase_nxt = gvbm_pkg::PH_Y;
            end
          end
          gvbm_pkg::PH_Y: begin
            if (ty_inc < sy) begin
              rx0_nxt   = bx_r;
              rx1_nxt   = tx_r;
              ry0_nxt   = ty_inc[AW-1:0];
              ry1_nxt   = ty_inc[AW-1:0];
              rb_nxt    = bz_r;
              cx_nxt    = SW'(bx_r);
              cy_nxt    = ty_inc;
              state_nxt = gvbm_pkg::ST_CHK_RD;
            end else begin
              phase_nxt = gvbm_pkg::PH_Z;
            end
          end
          gvbm_pkg::PH_Z: begin
            if (tz_inc < sz) begin
              rx0_nxt   = bx_r;
              rx1_nxt   = tx_r;
              ry0_nxt   = by_r;
              ry1_nxt   = ty_r;
              rb_nxt    = tz_inc[AW-1:0];
              cx_nxt    = SW'(bx_r);
              cy_nxt    = SW'(by_r);
              state_nxt = gvbm_pkg::ST_CHK_RD;
            end else begin
              phase_nxt = gvbm_pkg::PH_END;
            end
          end
          default: begin
            res_box_nxt = 1'b1;
            state_nxt   = gvbm_pkg::ST_OUT;
          end
        endcase
      end

      gvbm_pkg::ST_CHK_RD: state_nxt = gvbm_pkg::ST_CHK_EV;

      // every row of the region must hold the bit
      gvbm_pkg::ST_CHK_EV: begin
        if (!rd_data_r[rb_r]) begin
          unique case (phase_r)
            gvbm_pkg::PH_X: phase_nxt = gvbm_pkg::PH_Y;
            gvbm_pkg::PH_Y: phase_nxt = gvbm_pkg::PH_Z;
            default:        phase_nxt = gvbm_pkg::PH_END;
          endcase
          state_nxt = gvbm_pkg::ST_TRY;
        end else if (reg_last) begin
          cx_nxt    = SW'(rx0_r);
          cy_nxt    = SW'(ry0_r);
          state_nxt = gvbm_pkg::ST_CLR_RD;
        end else begin
          if (cy_r[AW-1:0] == ry1_r) begin
            cx_nxt = cx_r + SW'(1);
            cy_nxt = SW'(ry0_r);
          end else begin
            cy_nxt = cy_r + SW'(1);
          end
          state_nxt = gvbm_pkg::ST_CHK_RD;
        end
      end

      gvbm_pkg::ST_CLR_RD: state_nxt = gvbm_pkg::ST_CLR_EV;

      // clear the bit row by row, then take the extension (seed: start phase x)
      gvbm_pkg::ST_CLR_EV: begin
        mem_we = 1'b1;
        if (reg_last) begin
          unique case (phase_r)
            gvbm_pkg::PH_SEED: phase_nxt = gvbm_pkg::PH_X;
            gvbm_pkg::PH_X:    tx_nxt = tx_inc[AW-1:0];
            gvbm_pkg::PH_Y:    ty_nxt = ty_inc[AW-1:0];
            default:           tz_nxt = tz_inc[AW-1:0];
          endcase
          state_nxt = gvbm_pkg::ST_TRY;
        end else begin
          if (cy_r[AW-1:0] == ry1_r) begin
            cx_nxt = cx_r + SW'(1);
            cy_nxt = SW'(ry0_r);
          end else begin
            cy_nxt = cy_r + SW'(1);
          end
          state_nxt = gvbm_pkg::ST_CLR_RD;
        end
      end

      // hand the result to the output register
      gvbm_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = '0;
          out_data_nxt.box_valid = res_box_r;
          out_data_nxt.done_res  = res_done_r;
          if (res_box_r) begin
            out_data_nxt.from_x = 4'(bx_r);
            out_data_nxt.from_y = 4'(by_r);
            out_data_nxt.from_z = 4'(bz_r);
            out_data_nxt.to_x   = 4'(tx_r);
            out_data_nxt.to_y   = 4'(ty_r);
            out_data_nxt.to_z   = 4'(tz_r);
          end
          state_nxt = gvbm_pkg::ST_IDLE;
        end
      end

      default: state_nxt = gvbm_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gvbm_checker.sv =====
// Port-level checker for greedy_voxel_box_merge, bound to the top level.
// Depends on gvbm_pkg and greedy_voxel_box_merge_macros.svh.
`default_nettype none
`include "greedy_voxel_box_merge_macros.svh"

module gvbm_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire gvbm_pkg::out_item_t out_data
);

  // a stalled result holds
  `GVBM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // a result is a box or a done report, never both
  `GVBM_ASSERT(a_kind_excl, clk, rst_n, out_valid |-> !(out_data.box_valid && out_data.done_res), "box and done both set")

  // one item at a time: a transfer on the input closes it
  `GVBM_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready, "input open right after a transfer")

  // the memory sweep keeps the input closed after reset
  `GVBM_ASSERT_ALWAYS(a_wipe_closed, clk, !rst_n |=> !in_ready, "input open right after reset")

endmodule

bind greedy_voxel_box_merge gvbm_checker u_gvbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
